FILE: sv/awnc_pkg.sv
// ----------------------------------------------------------------------------
// awnc_pkg
// Shared widths and control types for the area-weighted neighbor centroid.
// ----------------------------------------------------------------------------
package awnc_pkg;

  // Field widths of one neighbor word and one centroid word
  localparam int POS_W  = 32;
  localparam int AREA_W = 24;
  localparam int PROD_W = POS_W + AREA_W;

  // Quotient bits are produced one per cycle
  localparam int STEP_W = $clog2(POS_W);

  // Per-cycle commands from the sequencer to every axis lane
  typedef struct packed {
    logic capture;  // register the incoming position
    logic mul;      // form weight * position
    logic acc;      // add the product into the running sum
    logic load;     // start a divide, clear the running sum
    logic step;     // one restoring-divide step
  } lane_ctrl_t;

  // Status handed to the merge stage with a finished divide
  typedef struct packed {
    logic load;              // quotients are final, take them
    logic zero_weight;
    logic valence_overflow;
  } merge_ctrl_t;

endpackage

FILE: sv/awnc_if.sv
// ----------------------------------------------------------------------------
// awnc_if
// Valid/ready channels for neighbor words and centroid words.
// ----------------------------------------------------------------------------
interface awnc_in_if import awnc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  nbr_x;
  logic signed [POS_W-1:0]  nbr_y;
  logic signed [POS_W-1:0]  nbr_z;
  logic        [AREA_W-1:0] nbr_area;
  logic                     is_last;

  modport source (output valid, nbr_x, nbr_y, nbr_z, nbr_area, is_last, input ready);
  modport sink   (input valid, nbr_x, nbr_y, nbr_z, nbr_area, is_last, output ready);
endinterface

interface awnc_out_if import awnc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] cen_x;
  logic signed [POS_W-1:0] cen_y;
  logic signed [POS_W-1:0] cen_z;
  logic                    zero_weight;
  logic                    valence_overflow;

  modport source (output valid, cen_x, cen_y, cen_z, zero_weight, valence_overflow,
                  input ready);
  modport sink   (input valid, cen_x, cen_y, cen_z, zero_weight, valence_overflow,
                  output ready);
endinterface

FILE: sv/awnc_lane.sv
// ----------------------------------------------------------------------------
// awnc_lane
// One axis: multiply-accumulate of weight * position and a bit-serial
// signed divide of the sum by the weight total.
// ----------------------------------------------------------------------------
module awnc_lane import awnc_pkg::*; #(
  parameter int ACC_W = 62,
  parameter int WT_W  = 30
) (
  input  logic                    clk,
  input  lane_ctrl_t              ctrl,
  input  logic signed [POS_W-1:0] pos,
  input  logic [AREA_W-1:0]       area,
  input  logic [WT_W-1:0]         den,
  output logic signed [POS_W-1:0] quo,
  input  logic                    rst_n
);

  logic signed [POS_W-1:0]  pos_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [WT_W-1:0]          rem_r;
  logic [POS_W-1:0]         quo_r;
  logic                     neg_r;

  logic signed [PROD_W:0]   mul_full;
  logic [ACC_W-1:0]         mag;
  logic [WT_W:0]            trial;
  logic [WT_W:0]            diff;

  // Signed position times unsigned weight
  assign mul_full = pos_r * $signed({1'b0, area});

  // Magnitude of the running sum for the divide
  assign mag = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);

  // Trial subtract: shift in the next dividend bit
  assign trial = {rem_r, quo_r[POS_W-1]};
  assign diff  = trial - {1'b0, den};

  // Hold position, product and running sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (ctrl.load) begin
      acc_r <= '0;
    end else if (ctrl.acc) begin
      acc_r <= acc_r + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      pos_r <= pos;
    end
    if (ctrl.mul) begin
      prod_r <= mul_full[PROD_W-1:0];
    end
  end

  // Divide: the high part of the magnitude is already below the divisor,
  // so only the low word needs shifting through
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem_r <= mag[ACC_W-1:POS_W];
      quo_r <= mag[POS_W-1:0];
      neg_r <= acc_r[ACC_W-1];
    end else if (ctrl.step) begin
      if (!diff[WT_W]) begin
        rem_r <= diff[WT_W-1:0];
        quo_r <= {quo_r[POS_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[WT_W-1:0];
        quo_r <= {quo_r[POS_W-2:0], 1'b0};
      end
    end
  end

  // Restore the sign, truncation toward zero
  assign quo = neg_r ? $signed(-quo_r) : $signed(quo_r);

endmodule

FILE: sv/awnc_ctrl.sv
// ----------------------------------------------------------------------------
// awnc_ctrl
// Sequencer: input handshake, neighbor count, weight total and divide steps.
// ----------------------------------------------------------------------------
module awnc_ctrl import awnc_pkg::*; #(
  parameter int MAX_VALENCE = 64,
  parameter int WT_W        = 30
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [AREA_W-1:0] in_area,
  input  logic              in_last,
  input  logic              out_busy,
  output lane_ctrl_t        lane_ctrl,
  output logic [AREA_W-1:0] area,
  output logic [WT_W-1:0]   den,
  output merge_ctrl_t       merge_ctrl
);

  localparam int CNT_W = $clog2(MAX_VALENCE + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_ACC  = 6'b000100,
    S_LOAD = 6'b001000,
    S_DIV  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic [WT_W-1:0]    wt_r;
  logic [WT_W-1:0]    den_r;
  logic [STEP_W-1:0]  step_r;
  logic [AREA_W-1:0]  area_r;
  logic               take_r;
  logic               last_r;
  logic               ovf_r;
  logic               zw_r;
  logic               ovf_out_r;
  logic               accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_ACC;
      S_ACC:   state_nxt = last_r ? S_LOAD : S_IDLE;
      S_LOAD:  state_nxt = S_DIV;
      S_DIV:   if (step_r == STEP_W'(POS_W - 1)) state_nxt = S_DONE;
      S_DONE:  if (!out_busy) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Count neighbors, sum the weights of the kept ones, drop the ones past the valence bound
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
      wt_r  <= '0;
    end else if (state_r == S_LOAD) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
      wt_r  <= '0;
    end else begin
      if (accept) begin
        if (cnt_r < CNT_W'(MAX_VALENCE)) begin
          cnt_r <= cnt_r + 1'b1;
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (state_r == S_ACC && take_r) begin
        wt_r <= wt_r + WT_W'(area_r);
      end
    end
  end

  // Hold the word's weight and flags while it is worked on
  always_ff @(posedge clk) begin
    if (accept) begin
      area_r <= in_area;
      last_r <= in_last;
      take_r <= (cnt_r < CNT_W'(MAX_VALENCE));
    end
  end

  // Latch divisor and result flags, advance the step count
  always_ff @(posedge clk) begin
    if (state_r == S_LOAD) begin
      den_r     <= wt_r;
      zw_r      <= (wt_r == '0);
      ovf_out_r <= ovf_r;
      step_r    <= '0;
    end else if (state_r == S_DIV) begin
      step_r <= step_r + 1'b1;
    end
  end

  assign lane_ctrl.capture = accept;
  assign lane_ctrl.mul     = (state_r == S_MUL);
  assign lane_ctrl.acc     = (state_r == S_ACC) && take_r;
  assign lane_ctrl.load    = (state_r == S_LOAD);
  assign lane_ctrl.step    = (state_r == S_DIV);

  assign area = area_r;
  assign den  = den_r;

  assign merge_ctrl.load             = (state_r == S_DONE) && !out_busy;
  assign merge_ctrl.zero_weight      = zw_r;
  assign merge_ctrl.valence_overflow = ovf_out_r;

endmodule

FILE: sv/area_weighted_neighbor_centroid.sv
// ----------------------------------------------------------------------------
// area_weighted_neighbor_centroid
// Weighted centroid of a vertex's neighbors, three axis lanes and a merge.
// ----------------------------------------------------------------------------
// Each neighbor word passes through capture, multiply and accumulate; the
// three axes run in parallel lanes. The word marked last then loads the
// divide and runs a restoring divide, one quotient bit per cycle, in each
// lane, then moves the centroid into the output register, waiting while it
// holds an unread centroid. No neighbor is taken meanwhile. The output
// register lets the next vertex's neighbors stream in while a centroid
// waits to be read. Neighbors beyond MAX_VALENCE are dropped and flagged; a
// zero weight sum returns a zero centroid with zero_weight set.
module area_weighted_neighbor_centroid import awnc_pkg::*; #(
  parameter int MAX_VALENCE = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  awnc_in_if.sink    in_ch,
  awnc_out_if.source out_ch
);

  localparam int WT_W  = AREA_W + $clog2(MAX_VALENCE);
  localparam int ACC_W = PROD_W + $clog2(MAX_VALENCE);

  lane_ctrl_t              lane_ctrl;
  merge_ctrl_t             merge_ctrl;
  logic [AREA_W-1:0]       area;
  logic [WT_W-1:0]         den;
  logic signed [POS_W-1:0] quo_x, quo_y, quo_z;
  logic                    out_valid_r;
  logic signed [POS_W-1:0] cen_x_r, cen_y_r, cen_z_r;
  logic                    zw_r, ovf_r;
  logic                    out_busy;

  assign out_busy = out_valid_r && !out_ch.ready;

  awnc_ctrl #(.MAX_VALENCE(MAX_VALENCE), .WT_W(WT_W)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_area    (in_ch.nbr_area),
    .in_last    (in_ch.is_last),
    .out_busy   (out_busy),
    .lane_ctrl  (lane_ctrl),
    .area       (area),
    .den        (den),
    .merge_ctrl (merge_ctrl)
  );

  awnc_lane #(.ACC_W(ACC_W), .WT_W(WT_W)) u_lane_x (
    .clk (clk), .ctrl (lane_ctrl), .pos (in_ch.nbr_x), .area (area),
    .den (den), .quo (quo_x), .rst_n (rst_n)
  );

  awnc_lane #(.ACC_W(ACC_W), .WT_W(WT_W)) u_lane_y (
    .clk (clk), .ctrl (lane_ctrl), .pos (in_ch.nbr_y), .area (area),
    .den (den), .quo (quo_y), .rst_n (rst_n)
  );

  awnc_lane #(.ACC_W(ACC_W), .WT_W(WT_W)) u_lane_z (
    .clk (clk), .ctrl (lane_ctrl), .pos (in_ch.nbr_z), .area (area),
    .den (den), .quo (quo_z), .rst_n (rst_n)
  );

  // Output word valid: set on a merge, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (merge_ctrl.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Merge the lane quotients; zero them when there was no weight
  always_ff @(posedge clk) begin
    if (merge_ctrl.load) begin
      cen_x_r <= merge_ctrl.zero_weight ? '0 : quo_x;
      cen_y_r <= merge_ctrl.zero_weight ? '0 : quo_y;
      cen_z_r <= merge_ctrl.zero_weight ? '0 : quo_z;
      zw_r    <= merge_ctrl.zero_weight;
      ovf_r   <= merge_ctrl.valence_overflow;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.cen_x            = cen_x_r;
  assign out_ch.cen_y            = cen_y_r;
  assign out_ch.cen_z            = cen_z_r;
  assign out_ch.zero_weight      = zw_r;
  assign out_ch.valence_overflow = ovf_r;

endmodule
